// ===== rtl/srcwd_pkg.sv =====
// ----------------------------------------------------------------------------
// srcwd_pkg
// Shared types, constants and the CRC-8 byte update for the sensor reply
// word decoder.
// ----------------------------------------------------------------------------
package srcwd_pkg;

   localparam logic [7:0] CrcPoly = 8'h31;
   localparam logic [7:0] CrcInit = 8'hFF;
   localparam logic [7:0] CrcTop  = 8'h80;

   // Quantity codes, one per six-byte group of the reply.
   localparam logic [1:0] QtyCarbonDioxide = 2'd0;
   localparam logic [1:0] QtyTemperature   = 2'd1;
   localparam logic [1:0] QtyHumidity      = 2'd2;

   // Place of a byte within its six-byte group.
   typedef enum logic [2:0] {
      SLOT_DATA0,
      SLOT_DATA1,
      SLOT_CHECK0,
      SLOT_DATA2,
      SLOT_DATA3,
      SLOT_CHECK1
   } slot_type;

   typedef struct packed {
      logic [1:0]  quantity;
      logic [31:0] word_bits;
      logic        crc_good;
   } result_type;

   // One byte through the CRC-8, most significant bit first.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                              input logic [7:0] data);
      logic [7:0] acc;
      acc = crc ^ data;
      for (int n = 0; n < 8; n++) begin
         if ((acc & CrcTop) != 8'h00) begin
            acc = {acc[6:0], 1'b0} ^ CrcPoly;
         end else begin
            acc = {acc[6:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

// ===== rtl/srcwd_frame_core.sv =====
// ----------------------------------------------------------------------------
// srcwd_frame_core
// Byte position tracking, CRC checking and word assembly for one reply.
// ----------------------------------------------------------------------------
module srcwd_frame_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic [7:0]              rx_byte,
   input  logic                    frame_start,
   output logic                    result_due,
   output srcwd_pkg::result_type   result
);
   import srcwd_pkg::*;

   slot_type    slot_ff, slot_in, slot_cur;
   logic [1:0]  group_ff, group_in, group_cur;
   logic [7:0]  check_ff, check_in;
   logic [31:0] held_ff, held_in;
   logic        first_good_ff, first_good_in;
   logic [7:0]  crc_from_init, crc_from_check;

   // A start mark forces the byte to the head of the reply.
   assign slot_cur  = frame_start ? SLOT_DATA0 : slot_ff;
   assign group_cur = frame_start ? QtyCarbonDioxide : group_ff;

   assign crc_from_init  = crc8_update(CrcInit, rx_byte);
   assign crc_from_check = crc8_update(check_ff, rx_byte);

   always_comb begin
      held_in         = held_ff;
      check_in        = check_ff;
      first_good_in   = first_good_ff;
      slot_in         = slot_type'(slot_cur + 3'd1);
      group_in        = group_cur;
      result_due      = 1'b0;
      result.quantity  = group_cur;
      result.word_bits = held_ff;
      result.crc_good  = first_good_ff && (check_ff == rx_byte);
      case (slot_cur)
         SLOT_DATA0: begin
            held_in  = {rx_byte, 24'h000000};
            check_in = crc_from_init;
         end
         SLOT_DATA1: begin
            held_in  = {held_ff[31:24], rx_byte, 16'h0000};
            check_in = crc_from_check;
         end
         SLOT_CHECK0: begin
            first_good_in = (check_ff == rx_byte);
            check_in      = CrcInit;
         end
         SLOT_DATA2: begin
            held_in  = {held_ff[31:16], rx_byte, 8'h00};
            check_in = crc_from_init;
         end
         SLOT_DATA3: begin
            held_in  = {held_ff[31:8], rx_byte};
            check_in = crc_from_check;
         end
         default: begin
            // Closing check byte: the group's word is complete.
            result_due = 1'b1;
            check_in   = CrcInit;
            slot_in    = SLOT_DATA0;
            group_in   = (group_cur == QtyHumidity) ? QtyCarbonDioxide
                                                    : group_cur + 2'd1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff       <= SLOT_DATA0;
         group_ff      <= QtyCarbonDioxide;
         check_ff      <= CrcInit;
         held_ff       <= '0;
         first_good_ff <= 1'b0;
      end else if (step_en) begin
         slot_ff       <= slot_in;
         group_ff      <= group_in;
         check_ff      <= check_in;
         held_ff       <= held_in;
         first_good_ff <= first_good_in;
      end
   end

endmodule

// ===== rtl/sensor_reply_crc_word_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// sensor_reply_crc_word_decoder_unit
// Decodes the 18-byte measurement reply of a gas sensor into three checked
// 32-bit words.
// ----------------------------------------------------------------------------
// The block takes one reply byte per transfer on the req_ channel and gives
// one result transfer on the rsp_ channel after the sixth, twelfth and
// eighteenth byte of a reply: carbon dioxide, temperature and relative
// humidity in that order. Every third byte is a CRC-8 (polynomial 0x31,
// start 0xFF, MSB first, no final XOR) over the two bytes before it; the
// result word holds the four data bytes of the group, first byte most
// significant, and crc_good is set only when both checks of the group
// matched. A word with a bad check is still delivered. Setting frame_start
// (req_tuser) on a byte makes it the first byte of a reply and drops any
// word being gathered; without it the position simply wraps after the
// eighteenth byte. The block accepts one byte in every cycle unless a
// closing check byte is held back as below. Each byte passes through an
// input register and then a single decode step into the result register,
// from which the result is presented on rsp_. A result waiting in the
// output register only holds back bytes that would close the next group;
// other bytes keep flowing.
// ----------------------------------------------------------------------------
module sensor_reply_crc_word_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] word_bits
   output logic [2:0]  rsp_tuser    // [1:0] quantity, [2] crc_good
);
   import srcwd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;

   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;

   logic       result_due;
   result_type result;
   logic       out_free;
   logic       advance;

   // The output register can take a new result when empty or being drained.
   assign out_free = !out_valid_ff || rsp_tready;

   // The held byte moves on unless it closes a group and the output is full.
   assign advance    = in_valid_ff && (!result_due || out_free);
   assign req_tready = !in_valid_ff || advance;

   srcwd_frame_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .rx_byte     (in_byte_ff),
      .frame_start (in_start_ff),
      .result_due  (result_due),
      .result      (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (advance && result_due) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load on their own handshakes and need no reset.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
      if (advance && result_due) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff.word_bits;
   assign rsp_tuser  = {out_data_ff.crc_good, out_data_ff.quantity};

endmodule

// ===== verif/tb_sensor_reply_crc_word_decoder_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sensor_reply_crc_word_decoder_unit
// Self-checking bench for the sensor reply decoder. Reply bytes go in on the
// req_ stream. A local decoder predicts each checked word, and every rsp_
// transfer is compared with the oldest prediction. Both sides idle and stall
// at random.
// ----------------------------------------------------------------------------
module tb_sensor_reply_crc_word_decoder_unit;
   import srcwd_pkg::*;

   localparam int ReplyBytes    = 18;
   localparam int GroupBytes    = 6;
   localparam int RandomBytes   = 2000;
   localparam int ReportLimit   = 10;
   // Idle cycles on both channels before the run is declared stuck. Sender gaps
   // and receiver stalls are both drawn from pick_idle; stalls can follow one
   // another, but a run of more than a handful is very unlikely, so this
   // leaves a wide margin.
   localparam int WatchdogLimit = 4000;

   // One reply byte waiting to be offered, with its timing attached.
   typedef struct {
      logic [7:0]  rx_byte;
      logic        frame_start;
      int unsigned gap;    // idle cycles before this byte is offered
      bit          drain;  // hold it back until every pending word has come
   } reply_byte_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;  // [7:0] rx_byte
   logic        req_tuser  = 1'b0;   // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [31:0] word_bits
   logic [2:0]  rsp_tuser;           // [1:0] quantity, [2] crc_good

   // Local copy of the decoder state, as it stands after the last accepted
   // byte.
   logic [4:0]  decode_position = 5'd0;
   logic [7:0]  decode_check    = CrcInit;
   logic [31:0] decode_word     = 32'h0;
   logic        decode_first_ok = 1'b0;

   reply_byte_type reply_bytes[$];   // bytes still to be offered
   result_type     pending_words[$]; // words predicted but not yet received

   int unsigned mismatch_count   = 0;
   int unsigned idle_cycles      = 0;
   int unsigned gap_left         = 0;
   int unsigned stall_left       = 0;
   int unsigned stall_phase_left = 0;
   bit          receiver_choppy  = 1'b0;
   bit          sender_calm      = 1'b0;

   sensor_reply_crc_word_decoder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // CRC-8 over one byte. The data is fed in bit by bit, most significant
   // first, and a feedback bit decides whether the polynomial is applied.
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] acc;
      logic       feedback;
      acc = crc;
      for (int i = 7; i >= 0; i--) begin
         feedback = acc[7] ^ data[i];
         acc = {acc[6:0], 1'b0} ^ (feedback ? CrcPoly : 8'h00);
      end
      return acc;
   endfunction

   // Length of an idle stretch: mostly short, now and then long.
   function automatic int unsigned pick_idle();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) begin
         return $urandom_range(3, 1);
      end else if (roll < 95) begin
         return $urandom_range(12, 4);
      end
      return $urandom_range(60, 20);
   endfunction

   // Corruption mask for a check byte. Most checks are left intact.
   function automatic logic [7:0] pick_flip();
      if ($urandom_range(99) < 88) begin
         return 8'h00;
      end
      return 8'($urandom_range(255, 1));
   endfunction

   // A data word, with the all-zero and all-one extremes now and then.
   function automatic logic [31:0] pick_word();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 5) begin
         return 32'h0000_0000;
      end else if (roll < 10) begin
         return 32'hFFFF_FFFF;
      end
      return $urandom();
   endfunction

   task automatic add_byte(input logic [7:0] rx, input logic start, input bit drain = 1'b0);
      reply_byte_type item;
      item.rx_byte     = rx;
      item.frame_start = start;
      item.gap         = (sender_calm || $urandom_range(99) < 55) ? 0 : pick_idle();
      item.drain       = drain;
      reply_bytes.push_back(item);
   endtask

   // One six-byte group: two data bytes and their check, twice. A non-zero
   // flip mask spoils the matching check byte.
   task automatic add_group(input logic [31:0] word, input logic [7:0] flip0,
                            input logic [7:0] flip1, input logic start, input bit drain);
      add_byte(word[31:24], start, drain);
      add_byte(word[23:16], 1'b0);
      add_byte(crc8_step(crc8_step(CrcInit, word[31:24]), word[23:16]) ^ flip0, 1'b0);
      add_byte(word[15:8], 1'b0);
      add_byte(word[7:0], 1'b0);
      add_byte(crc8_step(crc8_step(CrcInit, word[15:8]), word[7:0]) ^ flip1, 1'b0);
   endtask

   // Advances the local decoder by one accepted byte and queues the word
   // that the byte completes, if it closes a group.
   task automatic predict_reply_byte(input logic [7:0] rx, input logic start);
      logic [4:0] pos;
      slot_type   slot;
      result_type word;
      // A start mark always forces the first position of a reply, dropping
      // whatever was being gathered.
      pos = start ? 5'd0 : decode_position;
      if (pos >= ReplyBytes) begin
         pos = 5'd0;
      end
      slot = slot_type'(pos % GroupBytes);
      case (slot)
         SLOT_DATA0: begin
            decode_word  = {rx, 24'h0};
            decode_check = crc8_step(CrcInit, rx);
         end
         SLOT_DATA1: begin
            decode_word  = {decode_word[31:24], rx, 16'h0};
            decode_check = crc8_step(decode_check, rx);
         end
         SLOT_CHECK0: begin
            decode_first_ok = (decode_check == rx);
            decode_check    = CrcInit;
         end
         SLOT_DATA2: begin
            decode_word  = {decode_word[31:16], rx, 8'h0};
            decode_check = crc8_step(CrcInit, rx);
         end
         SLOT_DATA3: begin
            decode_word  = {decode_word[31:8], rx};
            decode_check = crc8_step(decode_check, rx);
         end
         default: begin
            // The closing check byte: the word is given even when a check
            // failed, with the good flag cleared.
            word.quantity  = 2'(pos / GroupBytes);
            word.word_bits = decode_word;
            word.crc_good  = decode_first_ok && (decode_check == rx);
            pending_words.push_back(word);
            decode_check   = CrcInit;
         end
      endcase
      // Without a start mark the position wraps after the last reply byte.
      pos = pos + 5'd1;
      decode_position = (pos >= ReplyBytes) ? 5'd0 : pos;
   endtask

   // Sender. A byte is offered as soon as the previous one has been taken
   // and its gap has run out; a byte marked for draining waits until every
   // predicted word has been received.
   always @(posedge clock) begin
      reply_byte_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_reply_byte(req_tdata, req_tuser);
         end
         if (!req_tvalid || req_tready) begin
            if (reply_bytes.size() == 0 ||
                (reply_bytes[0].drain && pending_words.size() != 0)) begin
               req_tvalid <= 1'b0;
            end else if (gap_left != 0) begin
               gap_left = gap_left - 1;
               req_tvalid <= 1'b0;
            end else begin
               item = reply_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= item.rx_byte;
               req_tuser  <= item.frame_start;
               gap_left = (reply_bytes.size() != 0) ? reply_bytes[0].gap : 0;
            end
         end
      end
   end

   // Receiver. Each result transfer is checked against the oldest predicted
   // word. Back-pressure runs in phases: some phases never stall, others
   // stall often for short or long stretches.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit) begin
                  $display("unexpected word: quantity %0d word %h crc_good %b",
                           rsp_tuser[1:0], rsp_tdata, rsp_tuser[2]);
               end
            end else begin
               want = pending_words.pop_front();
               if (rsp_tuser[1:0] !== want.quantity || rsp_tdata !== want.word_bits ||
                   rsp_tuser[2] !== want.crc_good) begin
                  mismatch_count++;
                  if (mismatch_count <= ReportLimit) begin
                     $write("word mismatch: expected quantity %0d word %h crc_good %b,",
                            want.quantity, want.word_bits, want.crc_good);
                     $display(" got quantity %0d word %h crc_good %b",
                              rsp_tuser[1:0], rsp_tdata, rsp_tuser[2]);
                  end
               end
            end
         end
         if (stall_phase_left == 0) begin
            stall_phase_left = $urandom_range(300, 40);
            receiver_choppy  = ($urandom_range(3) != 0);
         end else begin
            stall_phase_left = stall_phase_left - 1;
         end
         if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (receiver_choppy && $urandom_range(99) < 30) begin
            stall_left = pick_idle() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: a run in which neither channel moves for too long is stuck.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned roll;
      int unsigned count;
      bit          first_reply;

      // Directed part. A reply whose first group is clean and holds the extreme
      // byte values, whose middle group fails its first check and whose last group
      // fails its second, two bytes that only wrap round into a new reply,
      // and then a start mark in the middle of that reply with both checks
      // spoilt on an all-ones word.
      add_group(32'h0000_FFFF, 8'h00, 8'h00, 1'b1, 1'b0);
      add_group(32'h1234_5678, 8'h01, 8'h00, 1'b0, 1'b0);
      add_group(32'hBEEF_00FF, 8'h00, 8'h80, 1'b0, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h00, 1'b0);
      add_group(32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, 1'b0);

      // Random part. Most of it is well-formed replies with random words and
      // occasional bad checks; the rest is replies that rely on the wrap,
      // replies cut short by the next start mark, and loose noise bytes. The
      // first random reply, and a few later ones, wait for the decoder to
      // drain completely before they begin.
      count = reply_bytes.size() + RandomBytes;
      first_reply = 1'b1;
      while (reply_bytes.size() < count) begin
         sender_calm = ($urandom_range(6) == 0);
         roll = $urandom_range(99);
         if (roll < 75) begin
            add_group(pick_word(), pick_flip(), pick_flip(), 1'b1,
                      first_reply || $urandom_range(99) < 3);
            add_group(pick_word(), pick_flip(), pick_flip(), 1'b0, 1'b0);
            add_group(pick_word(), pick_flip(), pick_flip(), 1'b0, 1'b0);
            first_reply = 1'b0;
         end else if (roll < 85) begin
            for (int g = 0; g < 3; g++) begin
               add_group(pick_word(), pick_flip(), pick_flip(), 1'b0, 1'b0);
            end
         end else if (roll < 93) begin
            add_byte(8'($urandom()), 1'b1);
            repeat ($urandom_range(16, 1)) add_byte(8'($urandom()), 1'b0);
         end else begin
            repeat ($urandom_range(8, 1)) begin
               add_byte(8'($urandom()), ($urandom_range(3) == 0));
            end
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Checks are made at the falling edge, where every clocked update of
      // the rising edge has settled.
      do @(negedge clock); while (reply_bytes.size() != 0 || req_tvalid);
      do @(negedge clock); while (pending_words.size() != 0);
      // The decoder is two stages deep; the extra wait catches any stray
      // word that it might still give.
      repeat (8) @(negedge clock);

      if (mismatch_count == 0 && pending_words.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
